>>> rtl/wbps_pkg.sv
// Package for the wildcard byte pattern search block.
// Holds shared constants, register indexes and the structs passed between modules.
// Depends on nothing; every other file in rtl uses it.

package wbps_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_PATTERN_DEF = 8;
    localparam int OFFSET_BITS_DEF = 32;

    // Field widths fixed by the interface.
    localparam int BYTE_W       = 8;
    localparam int PATTERN_W    = 64;
    localparam int MASK_W       = 8;
    localparam int LENGTH_W     = 4;
    localparam int MATCH_OFF_W  = 32;

    // Register port geometry: 64-bit registers at byte address 8*i.
    localparam int APB_DATA_W   = 64;
    localparam int APB_ADDR_W   = 5;
    localparam int REG_IDX_W    = 2;
    localparam int REG_IDX_LSB  = 3;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WILDCARD_MASK  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Current configuration as seen by the compare logic.
    typedef struct packed {
        logic [PATTERN_W-1:0] pattern_bytes;
        logic [MASK_W-1:0]    wildcard_mask;
        logic [LENGTH_W-1:0]  pattern_length;
    } cfg_t;

    // Outcome of one byte: whether a result is produced, and its fields.
    typedef struct packed {
        logic                   emit;
        logic                   found;
        logic [MATCH_OFF_W-1:0] match_offset;
    } result_t;

endpackage

>>> rtl/wbps_cfg.sv
// Configuration register file for the wildcard byte pattern search block.
// APB-style write/read port holding pattern, wildcard mask and pattern length.
// Depends on wbps_pkg.

module wbps_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output wbps_pkg::cfg_t                   cfg
);

    wbps_pkg::cfg_t                    cfg_reg;
    wbps_pkg::cfg_t                    cfg_next;
    logic [wbps_pkg::REG_IDX_W-1:0]    reg_idx;
    logic                              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[wbps_pkg::REG_IDX_LSB +: wbps_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;

    // Register write decode; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                wbps_pkg::REG_PATTERN_BYTES:
                    cfg_next.pattern_bytes = pwdata[wbps_pkg::PATTERN_W-1:0];
                wbps_pkg::REG_WILDCARD_MASK:
                    cfg_next.wildcard_mask = pwdata[wbps_pkg::MASK_W-1:0];
                wbps_pkg::REG_PATTERN_LENGTH:
                    cfg_next.pattern_length = pwdata[wbps_pkg::LENGTH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_idx)
            wbps_pkg::REG_PATTERN_BYTES:
                prdata = wbps_pkg::APB_DATA_W'(cfg_reg.pattern_bytes);
            wbps_pkg::REG_WILDCARD_MASK:
                prdata = wbps_pkg::APB_DATA_W'(cfg_reg.wildcard_mask);
            wbps_pkg::REG_PATTERN_LENGTH:
                prdata = wbps_pkg::APB_DATA_W'(cfg_reg.pattern_length);
            default:
                prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/wbps_match.sv
// Window, byte counter and masked compare for the wildcard byte pattern search.
// Keeps the per-buffer state and decides the result for each byte it is stepped with.
// Depends on wbps_pkg.

module wbps_match
#(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [wbps_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  wbps_pkg::cfg_t                cfg,
    output wbps_pkg::result_t             result
);

    localparam int WIDE_W = (OFFSET_BITS > wbps_pkg::MATCH_OFF_W) ?
                            OFFSET_BITS : wbps_pkg::MATCH_OFF_W;

    logic [wbps_pkg::BYTE_W-1:0] window_reg   [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0] window_next  [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0] window_shift [MAX_PATTERN];
    logic [OFFSET_BITS-1:0]      count_reg;
    logic [OFFSET_BITS-1:0]      count_next;
    logic [OFFSET_BITS-1:0]      count_inc;
    logic                        reported_reg;
    logic                        reported_next;
    logic [MAX_PATTERN:1]        len_hit;
    logic                        hit;
    logic                        len_ok;
    logic [OFFSET_BITS-1:0]      offset;
    logic [WIDE_W-1:0]           offset_wide;

    // Shifted window and saturating count as they stand after this byte.
    always_comb
    begin
        window_shift[0] = data_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            window_shift[i] = window_reg[i-1];
        end
        count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    // Masked compare for every possible pattern length, newest byte last in pattern.
    always_comb
    begin
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            len_hit[l] = 1'b1;
            for (int j = 0; j < l; j++)
            begin
                if (!cfg.wildcard_mask[j] &&
                    (window_shift[l-1-j] != cfg.pattern_bytes[8*j +: 8]))
                begin
                    len_hit[l] = 1'b0;
                end
            end
        end
    end

    // Select the configured length; zero, oversized or too few bytes never match.
    always_comb
    begin
        hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            if (cfg.pattern_length == wbps_pkg::LENGTH_W'(l))
            begin
                hit = len_hit[l];
            end
        end
        len_ok = (count_inc >= OFFSET_BITS'(cfg.pattern_length));
        hit    = hit && len_ok && !reported_reg;
    end

    // Start offset, clamped to the result field width.
    always_comb
    begin
        offset      = count_inc - OFFSET_BITS'(cfg.pattern_length);
        offset_wide = WIDE_W'(offset);
        result.emit  = hit || (last_byte && !reported_reg);
        result.found = hit;
        if (!hit)
        begin
            result.match_offset = '0;
        end
        else if (offset_wide > WIDE_W'({wbps_pkg::MATCH_OFF_W{1'b1}}))
        begin
            result.match_offset = '1;
        end
        else
        begin
            result.match_offset = offset_wide[wbps_pkg::MATCH_OFF_W-1:0];
        end
    end

    // State update; the final byte of a buffer clears count and match flag.
    always_comb
    begin
        window_next   = window_reg;
        count_next    = count_reg;
        reported_next = reported_reg;
        if (step)
        begin
            if (!reported_reg)
            begin
                window_next   = window_shift;
                count_next    = count_inc;
                reported_next = hit;
            end
            if (last_byte)
            begin
                count_next    = '0;
                reported_next = 1'b0;
            end
        end
    end

    // Window bytes are only read once the count covers them, so they need no reset.
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            reported_reg <= reported_next;
        end
    end

endmodule

>>> rtl/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search, top level.
// A byte is held in the input register, and its result is then registered in the output register.
// Throughput: one byte per cycle, limited only by the output stall.
// The input register holds one byte while a result waits in the output register.
// Reset clears configuration, byte count, match flag and both valid flags.
// Depends on wbps_pkg, wbps_cfg and wbps_match.

module wildcard_byte_pattern_search
#(
    parameter int MAX_PATTERN = wbps_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS = wbps_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Byte stream in.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [wbps_pkg::BYTE_W-1:0]         data_byte,
    input  logic                                last_byte,
    // Results out.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [wbps_pkg::MATCH_OFF_W-1:0]    match_offset
);

    wbps_pkg::cfg_t                     cfg;
    wbps_pkg::result_t                  result;

    logic                               s1_valid_reg;
    logic                               s1_valid_next;
    logic [wbps_pkg::BYTE_W-1:0]        s1_byte_reg;
    logic                               s1_last_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic                               out_found_reg;
    logic [wbps_pkg::MATCH_OFF_W-1:0]   out_offset_reg;
    logic                               out_free;
    logic                               step;
    logic                               in_xfer;

    // Register file.
    wbps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: the held byte is processed when the output register can take a result.
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // Input register.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // Window, counter and compare.
    wbps_match
    #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_match
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && result.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.emit)
        begin
            out_found_reg  <= result.found;
            out_offset_reg <= result.match_offset;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign match_offset = out_offset_reg;

endmodule

>>> rtl/wbps_checker.sv
// Port-level checker for the wildcard byte pattern search block, bound to the top level.
// Watches the byte and result channels over time.
// Depends on wbps_pkg and wildcard_byte_pattern_search.

module wbps_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                found,
    input  logic [wbps_pkg::MATCH_OFF_W-1:0]    match_offset
);

    // A not-found result always carries a zero offset.
    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (match_offset == '0))
        else $error("not-found result with nonzero offset");

    // The input only stalls when a result is waiting and the output is stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output can move");

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(found) && $stable(match_offset)))
        else $error("stalled result changed or dropped");

    // With no result waiting and no past input transfer still able to reach the output, no new result can appear.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !$past(in_valid && !in_stall) && !$past(in_valid && !in_stall, 2))
        |=> !out_valid)
        else $error("result appeared without a byte transfer");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);

>>> test/wildcard_byte_pattern_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_byte_pattern_search: streams byte buffers,
// tracks expected found/offset reports in a scoreboard class and compares every transfer.
// Depends on wbps_pkg and the wildcard_byte_pattern_search top level only.

module wildcard_byte_pattern_search_tb;

    localparam int MAX_PAT = wbps_pkg::MAX_PATTERN_DEF;
    localparam int CNT_W = wbps_pkg::OFFSET_BITS_DEF;
    localparam logic [wbps_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [wbps_pkg::PATTERN_W-1:0] DIR_PATTERN = 64'h007F_80C3_3C01_FEFF;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int RANDOM_PHASES = 12;

    typedef struct packed {
        logic                             found;
        logic [wbps_pkg::MATCH_OFF_W-1:0] offset;
    } search_report_t;

    // Tracks the search state of the current buffer and the reports it must produce.
    class match_tracker;
        logic [wbps_pkg::PATTERN_W-1:0] pattern;
        logic [wbps_pkg::MASK_W-1:0]    wild;
        logic [wbps_pkg::LENGTH_W-1:0]  len;
        logic [wbps_pkg::BYTE_W-1:0]    window [MAX_PAT];
        logic [CNT_W-1:0]               seen;
        bit                             reported;
        search_report_t                 pending [$];
        int                             errors;

        function new();
            pattern = '0;
            wild = '0;
            len = '0;
            errors = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            foreach (window[i]) window[i] = '0;
            seen = '0;
            reported = 1'b0;
        endfunction

        // Queues one expected report behind the ones already waiting.
        function void note_report(search_report_t rep);
            pending.insert(pending.size(), rep);
        endfunction

        function void set_reg(logic [wbps_pkg::REG_IDX_W-1:0] idx,
                              logic [wbps_pkg::APB_DATA_W-1:0] value);
            case (idx)
                wbps_pkg::REG_PATTERN_BYTES:  pattern = value[wbps_pkg::PATTERN_W-1:0];
                wbps_pkg::REG_WILDCARD_MASK:  wild = value[wbps_pkg::MASK_W-1:0];
                wbps_pkg::REG_PATTERN_LENGTH: len = value[wbps_pkg::LENGTH_W-1:0];
                default: ;
            endcase
        endfunction

        // The newest len bytes match when every unmasked pattern byte agrees.
        function bit window_hit();
            if (len == 0 || len > MAX_PAT || seen < len)
                return 1'b0;
            for (int j = 0; j < len; j++)
            begin
                if (!wild[j] && window[len - 1 - j] != pattern[8*j +: 8])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(logic [wbps_pkg::BYTE_W-1:0] value, logic is_last);
            search_report_t rep;
            if (!reported)
            begin
                for (int i = MAX_PAT - 1; i > 0; i--)
                    window[i] = window[i - 1];
                window[0] = value;
                if (seen != '1)
                    seen++;
                if (window_hit())
                begin
                    rep.found = 1'b1;
                    rep.offset = wbps_pkg::MATCH_OFF_W'(seen - len);
                    note_report(rep);
                    reported = 1'b1;
                end
                else if (is_last)
                begin
                    rep.found = 1'b0;
                    rep.offset = '0;
                    note_report(rep);
                end
            end
            if (is_last)
                clear_buffer();
        endfunction

        function void check_report(logic got_found,
                                   logic [wbps_pkg::MATCH_OFF_W-1:0] got_offset);
            search_report_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result: found=%0b match_offset=%0d", got_found, got_offset);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got_found !== want.found)
            begin
                $error("found: expected %0b, actual %0b", want.found, got_found);
                errors++;
            end
            if (got_offset !== want.offset)
            begin
                $error("match_offset: expected %0d, actual %0d", want.offset, got_offset);
                errors++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [wbps_pkg::APB_ADDR_W-1:0]  paddr;
    logic [wbps_pkg::APB_DATA_W-1:0]  pwdata;
    logic [wbps_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             in_valid;
    logic                             in_stall;
    logic [wbps_pkg::BYTE_W-1:0]      data_byte;
    logic                             last_byte;
    logic                             out_valid;
    logic                             out_stall;
    logic                             found;
    logic [wbps_pkg::MATCH_OFF_W-1:0] match_offset;

    match_tracker                tracker;
    logic [wbps_pkg::BYTE_W-1:0] stream_q [$];
    int                          send_idle_pct;
    int                          recv_idle_pct;
    int                          bytes_sent;

    wildcard_byte_pattern_search dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check every result transfer against the oldest expected report.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            tracker.check_report(found, match_offset);
    end

    // Watchdog for a hung block.
    initial
    begin
        #3_000_000;
        $display("** wildcard_byte_pattern_search: FAILED **");
        $finish;
    end

    // One register write; psel stays high so writes can follow back to back.
    task automatic write_reg(input logic [wbps_pkg::REG_IDX_W-1:0] idx,
                             input logic [wbps_pkg::APB_DATA_W-1:0] value);
        logic [wbps_pkg::APB_ADDR_W-1:0] addr;
        addr = '0;
        addr[wbps_pkg::REG_IDX_LSB +: wbps_pkg::REG_IDX_W] = idx;
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_reg(idx, value);
        penable <= 1'b0;
    endtask

    // Writes all three registers, with junk above the mask and length fields.
    task automatic configure(input logic [wbps_pkg::PATTERN_W-1:0] pat,
                             input logic [wbps_pkg::MASK_W-1:0] mask,
                             input logic [wbps_pkg::LENGTH_W-1:0] plen);
        write_reg(wbps_pkg::REG_PATTERN_BYTES, pat);
        write_reg(wbps_pkg::REG_WILDCARD_MASK, {$urandom, 24'($urandom), mask});
        write_reg(wbps_pkg::REG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
        psel <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] value, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
        tracker.take_byte(value, is_last);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_byte(stream_q[i], i == stream_q.size() - 1);
    endtask

    // Holds the input idle until every expected report has been seen.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Adds one byte at the end of the buffer being built.
    function automatic void append_byte(logic [wbps_pkg::BYTE_W-1:0] value);
        stream_q.insert(stream_q.size(), value);
    endfunction

    function automatic void add_noise(int count);
        repeat (count) append_byte(wbps_pkg::BYTE_W'($urandom));
    endfunction

    // Mostly buffers that hold the pattern, some broken copies, some plain noise.
    function automatic void build_random_buffer();
        int kind;
        int plen;
        int pos;
        kind = $urandom_range(9);
        plen = tracker.len;
        stream_q.delete();
        if (plen == 0 || plen > MAX_PAT || kind >= 8)
        begin
            add_noise($urandom_range(12, 1));
            return;
        end
        add_noise($urandom_range(6, 0));
        for (int j = 0; j < plen; j++)
            append_byte(tracker.wild[j] ? wbps_pkg::BYTE_W'($urandom)
                                        : tracker.pattern[8*j +: 8]);
        if (kind == 6)
        begin
            // Corrupt one byte of the embedded copy.
            pos = stream_q.size() - plen + $urandom_range(plen - 1);
            stream_q[pos] = stream_q[pos] ^ wbps_pkg::BYTE_W'($urandom_range(255, 1));
        end
        else if (kind == 7)
        begin
            // Cut the copy short.
            repeat ($urandom_range(plen, 1)) void'(stream_q.pop_back());
        end
        add_noise($urandom_range(4, 0));
        if (stream_q.size() == 0)
            add_noise(1);
    endfunction

    initial
    begin
        logic [wbps_pkg::PATTERN_W-1:0] pat;
        logic [wbps_pkg::MASK_W-1:0]    mask;
        logic [wbps_pkg::LENGTH_W-1:0]  plen;

        tracker = new();
        send_idle_pct = 32;
        recv_idle_pct = 87;
        bytes_sent = 0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        data_byte <= '0;
        last_byte <= 1'b0;
        out_stall <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length after reset: every buffer ends not-found, even a single byte.
        stream_q = '{8'h00, 8'hFF};
        send_stream();
        stream_q = '{8'hA5};
        send_stream();

        // Full eight-byte pattern: a match on the last byte, then a buffer too short.
        wait_for_results();
        write_reg(REG_UNMAPPED, {$urandom, $urandom});
        configure(DIR_PATTERN, 8'h00, 4'd8);
        stream_q.delete();
        for (int j = 0; j < MAX_PAT; j++)
            append_byte(DIR_PATTERN[8*j +: 8]);
        send_stream();
        stream_q = '{DIR_PATTERN[7:0], DIR_PATTERN[15:8], DIR_PATTERN[23:16]};
        send_stream();

        // Two bytes with the first one masked; the bytes after the match are ignored.
        wait_for_results();
        configure(DIR_PATTERN, 8'h01, 4'd2);
        stream_q = '{8'h12, 8'h34, DIR_PATTERN[15:8], 8'h56, 8'h78};
        send_stream();

        // A length above the pattern size never matches.
        wait_for_results();
        configure(DIR_PATTERN, 8'hFF, 4'd15);
        stream_q = '{8'hFF, 8'h00};
        send_stream();

        // Random phases, each with its own configuration and idling mix.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 87;
            end
            else if (p < 8)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (p == 3)
                plen = 4'd0;
            else if (p == 5)
                plen = wbps_pkg::LENGTH_W'($urandom_range(15, MAX_PAT + 1));
            else if (p == 0 || p == 2)
                plen = wbps_pkg::LENGTH_W'(MAX_PAT);
            else if (p == 1)
                plen = 4'd1;
            else
                plen = wbps_pkg::LENGTH_W'($urandom_range(MAX_PAT, 1));

            if (p == 0)
                mask = 8'h00;
            else if (p == 2)
                mask = 8'hFF;
            else if ($urandom_range(3) == 0)
                mask = 8'h00;
            else
                mask = wbps_pkg::MASK_W'($urandom);

            if (p == 6)
                pat = '1;
            else if (p == 7)
                pat = '0;
            else
                pat = {$urandom, $urandom};

            wait_for_results();
            configure(pat, mask, plen);
            bytes_sent = 0;
            while (bytes_sent < ITEMS_PER_PHASE)
            begin
                build_random_buffer();
                send_stream();
            end
        end

        wait_for_results();
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("** wildcard_byte_pattern_search: PASSED **");
        else
            $display("** wildcard_byte_pattern_search: FAILED **");
        $finish;
    end

endmodule
